// ===== rtl/iph_pkg.sv =====
// Shared types, codes and sizes for the indexed priority heap.
package iph_pkg;

	localparam int MAX_VARS_DEF = 1024;
	localparam int VAR_W        = $clog2(MAX_VARS_DEF);
	localparam int KEY_W        = 32;
	localparam int CNT_W        = $clog2(MAX_VARS_DEF + 1);
	localparam int KIND_W       = 2;

	localparam logic [KIND_W-1:0] KIND_SET_KEY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

	// Datapath commands issued by the controller
	typedef struct packed {
		logic load;       // latch the input transaction
		logic clr_wr;     // clearing pass write
		logic key_wr;     // write the new key
		logic set_item;   // re-keyed variable becomes the moving item
		logic ins_init;   // place variable at the end of the heap
		logic rd_root;    // read slot 0 and the last slot
		logic rem_init;   // drop the root, take the last entry as moving item
		logic err_set;    // remove on an empty heap
		logic rem_key;    // capture the key of the refill item
		logic up_key;     // read the parent key
		logic up_step;    // compare and maybe swap one level up
		logic dn_rd;      // read both child slots
		logic dn_key;     // read both child keys
		logic dn_step;    // compare and maybe swap one level down
		logic fin;        // write the moving item at its final place
	} iph_cmd_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic clr_last;
		logic at_root;
		logic up_more;
		logic no_child;
		logic dn_more;
		logic present;
		logic in_range;
		logic full;
		logic empty;
		logic remain;
	} iph_sts_t;

endpackage

// ===== rtl/iph_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module iph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/iph_datapath.sv =====
// Heap datapath: slot, position and key memories with sift registers.
module iph_datapath #(
	parameter int MAX_VARS = iph_pkg::MAX_VARS_DEF,
	parameter int AW       = $clog2(MAX_VARS),
	parameter int CW       = $clog2(MAX_VARS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iph_pkg::iph_cmd_t           cmd,
	output iph_pkg::iph_sts_t           sts,
	input  logic [AW-1:0]               var_index,
	input  logic [iph_pkg::KEY_W-1:0]   new_key,
	output logic [AW-1:0]               popped_var,
	output logic                        popped_valid,
	output logic                        empty_error,
	output logic [CW-1:0]               heap_count
);

	localparam int KW = iph_pkg::KEY_W;
	// position entry: present bit over position
	localparam int PW = AW + 1;

	logic [AW-1:0] var_q, item_q, cand_a_q, cand_b_q;
	logic [KW-1:0] key_q, item_key_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	logic          in_range_q;
	logic [AW-1:0] popped_var_q;
	logic          popped_valid_q, empty_error_q;

	// memory ports
	logic          s_we, p_we, k_we;
	logic [AW-1:0] s_wa, p_wa, k_wa;
	logic [AW-1:0] s_wd;
	logic [PW-1:0] p_wd;
	logic [KW-1:0] k_wd;
	logic [AW-1:0] s_ra, s_rb, p_ra, k_ra, k_rb;
	logic [AW-1:0] s_da, s_db;
	logic [PW-1:0] p_da, p_db;
	logic [KW-1:0] k_da, k_db;

	iph_ram #(.WIDTH(AW), .DEPTH(MAX_VARS)) u_slots (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.raddr_a(s_ra), .rdata_a(s_da), .raddr_b(s_rb), .rdata_b(s_db));
	iph_ram #(.WIDTH(PW), .DEPTH(MAX_VARS)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
		.raddr_a(p_ra), .rdata_a(p_da), .raddr_b(p_ra), .rdata_b(p_db));
	iph_ram #(.WIDTH(KW), .DEPTH(MAX_VARS)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd),
		.raddr_a(k_ra), .rdata_a(k_da), .raddr_b(k_rb), .rdata_b(k_db));

	// child and parent positions of the moving item
	logic [AW+1:0] lc, rc, cnt_x;
	logic [AW-1:0] par;
	logic [AW-1:0] cnt_last;
	assign lc       = {1'b0, pos_q, 1'b1};
	assign rc       = {1'b0, pos_q, 1'b0} + (AW+2)'(2);
	assign cnt_x    = (AW+2)'(cnt_q);
	assign par      = (pos_q - AW'(1)) >> 1;
	assign cnt_last = AW'(cnt_q - CW'(1));

	// child choice and swap decisions
	logic          rc_ok, pick_r, up_sw, dn_sw;
	logic [KW-1:0] child_key;
	logic [AW-1:0] child_var;
	assign rc_ok     = rc < cnt_x;
	assign pick_r    = rc_ok && (k_db < k_da);
	assign child_key = pick_r ? k_db : k_da;
	assign child_var = pick_r ? cand_b_q : cand_a_q;
	assign up_sw     = item_key_q < k_da;
	assign dn_sw     = child_key < item_key_q;

	// memory addressing and writes
	always_comb begin
		s_we = 1'b0; s_wa = pos_q;  s_wd = item_q;
		p_we = 1'b0; p_wa = item_q; p_wd = {1'b1, pos_q};
		k_we = 1'b0; k_wa = var_q;  k_wd = key_q;
		s_ra = par; s_rb = par;
		p_ra = var_q;
		k_ra = var_q; k_rb = var_q;
		if (cmd.clr_wr) begin
			p_we = 1'b1; p_wa = clr_q; p_wd = '0;
			k_we = 1'b1; k_wa = clr_q; k_wd = '0;
		end
		if (cmd.key_wr) begin
			k_we = 1'b1;
		end
		if (cmd.rd_root) begin
			s_ra = '0; s_rb = cnt_last;
		end
		if (cmd.rem_init) begin
			// root variable leaves the heap; fetch the refill key
			p_we = 1'b1; p_wa = s_da; p_wd = '0;
			k_ra = s_db;
		end
		if (cmd.up_key) begin
			k_ra = s_da;
		end
		if (cmd.up_step && up_sw) begin
			s_we = 1'b1; s_wd = cand_a_q;
			p_we = 1'b1; p_wa = cand_a_q;
		end
		if (cmd.dn_rd) begin
			s_ra = AW'(lc); s_rb = rc_ok ? AW'(rc) : AW'(lc);
		end
		if (cmd.dn_key) begin
			k_ra = s_da; k_rb = s_db;
		end
		if (cmd.dn_step && dn_sw) begin
			s_we = 1'b1; s_wd = child_var;
			p_we = 1'b1; p_wa = child_var;
		end
		if (cmd.fin) begin
			s_we = 1'b1; p_we = 1'b1;
		end
	end

	// count, clearing pointer and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			clr_q          <= '0;
			popped_valid_q <= 1'b0;
			empty_error_q  <= 1'b0;
			popped_var_q   <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				popped_valid_q <= 1'b0;
				empty_error_q  <= 1'b0;
				popped_var_q   <= '0;
			end
			if (cmd.ins_init) cnt_q <= cnt_q + CW'(1);
			if (cmd.rem_init) begin
				cnt_q          <= cnt_q - CW'(1);
				popped_valid_q <= 1'b1;
				popped_var_q   <= s_da;
			end
			if (cmd.err_set) empty_error_q <= 1'b1;
		end
	end

	// payload and sift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			var_q      <= var_index;
			key_q      <= new_key;
			in_range_q <= {1'b0, var_index} < (AW+1)'(MAX_VARS);
		end
		if (cmd.set_item) begin
			item_q     <= var_q;
			item_key_q <= key_q;
			pos_q      <= p_da[AW-1:0];
		end
		if (cmd.ins_init) begin
			item_q     <= var_q;
			item_key_q <= k_da;
			pos_q      <= AW'(cnt_q);
		end
		if (cmd.rem_init) begin
			item_q <= s_db;
			pos_q  <= '0;
		end
		if (cmd.rem_key) item_key_q <= k_da;
		if (cmd.up_key) cand_a_q <= s_da;
		if (cmd.up_step && up_sw) pos_q <= par;
		if (cmd.dn_key) begin
			cand_a_q <= s_da;
			cand_b_q <= s_db;
		end
		if (cmd.dn_step && dn_sw) pos_q <= AW'(pick_r ? rc : lc);
	end

	assign popped_var   = popped_var_q;
	assign popped_valid = popped_valid_q;
	assign empty_error  = empty_error_q;
	assign heap_count   = cnt_q;

	always_comb begin
		sts.clr_last = clr_q == AW'(MAX_VARS - 1);
		sts.at_root  = pos_q == '0;
		sts.up_more  = up_sw;
		sts.no_child = lc >= cnt_x;
		sts.dn_more  = dn_sw;
		sts.present  = p_db[AW];
		sts.in_range = in_range_q;
		sts.full     = cnt_q == CW'(MAX_VARS);
		sts.empty    = cnt_q == '0;
		sts.remain   = cnt_q != CW'(1);
	end

endmodule

// ===== rtl/iph_ctrl.sv =====
// Heap controller: sequences clearing, insert, re-key and remove transactions.
module iph_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [iph_pkg::KIND_W-1:0] kind,
	output logic                       busy,
	output logic                       done,
	output iph_pkg::iph_cmd_t          cmd,
	input  iph_pkg::iph_sts_t          sts
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_VAR   = 4'd3;
	localparam logic [3:0] S_RINIT = 4'd4;
	localparam logic [3:0] S_RKEY  = 4'd5;
	localparam logic [3:0] S_UPRD  = 4'd6;
	localparam logic [3:0] S_UPKEY = 4'd7;
	localparam logic [3:0] S_UPCMP = 4'd8;
	localparam logic [3:0] S_DNRD  = 4'd9;
	localparam logic [3:0] S_DNKEY = 4'd10;
	localparam logic [3:0] S_DNCMP = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0] state_q, state_d;
	logic [iph_pkg::KIND_W-1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			kind_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start && !busy) kind_q <= kind;
		end
	end

	assign busy = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				// position and key of the variable are being read
				unique case (kind_q)
					iph_pkg::KIND_SET_KEY: begin
						if (sts.in_range) begin
							cmd.key_wr = 1'b1;
							state_d    = S_VAR;
						end else begin
							state_d = S_DONE;
						end
					end
					iph_pkg::KIND_INSERT: state_d = sts.in_range ? S_VAR : S_DONE;
					iph_pkg::KIND_REMOVE: begin
						if (sts.empty) begin
							cmd.err_set = 1'b1;
							state_d     = S_DONE;
						end else begin
							cmd.rd_root = 1'b1;
							state_d     = S_RINIT;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_VAR: begin
				if (kind_q == iph_pkg::KIND_SET_KEY) begin
					if (sts.present) begin
						cmd.set_item = 1'b1;
						state_d      = S_UPRD;
					end else begin
						state_d = S_DONE;
					end
				end else if (!sts.present && !sts.full) begin
					cmd.ins_init = 1'b1;
					state_d      = S_UPRD;
				end else begin
					state_d = S_DONE;
				end
			end
			// sift up: parent slot, parent key, compare
			S_UPRD: state_d = sts.at_root ? S_FIN : S_UPKEY;
			S_UPKEY: begin
				cmd.up_key = 1'b1;
				state_d    = S_UPCMP;
			end
			S_UPCMP: begin
				cmd.up_step = 1'b1;
				state_d     = sts.up_more ? S_UPRD : S_FIN;
			end
			S_RINIT: begin
				cmd.rem_init = 1'b1;
				state_d      = sts.remain ? S_RKEY : S_DONE;
			end
			S_RKEY: begin
				cmd.rem_key = 1'b1;
				state_d     = S_DNRD;
			end
			// sift down: child slots, child keys, compare
			S_DNRD: begin
				if (sts.no_child) begin
					state_d = S_FIN;
				end else begin
					cmd.dn_rd = 1'b1;
					state_d   = S_DNKEY;
				end
			end
			S_DNKEY: begin
				cmd.dn_key = 1'b1;
				state_d    = S_DNCMP;
			end
			S_DNCMP: begin
				cmd.dn_step = 1'b1;
				state_d     = sts.dn_more ? S_DNRD : S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/indexed_priority_heap.sv =====
// Indexed binary min-heap: top level joining controller and datapath.
// A transaction that leaves the heap untouched skips the sift and goes on to the result strobe;
// each heap level visited takes a slot read, a key read and a compare.
// Throughput: one transaction at a time; busy drops the cycle after the strobe.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset: heap empty; a clearing pass over all MAX_VARS entries keeps busy high.
module indexed_priority_heap #(
	parameter int MAX_VARS = iph_pkg::MAX_VARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [iph_pkg::KIND_W-1:0]       kind,
	input  logic [$clog2(MAX_VARS)-1:0]      var_index,
	input  logic [iph_pkg::KEY_W-1:0]        new_key,
	output logic [$clog2(MAX_VARS)-1:0]      popped_var,
	output logic                             popped_valid,
	output logic                             empty_error,
	output logic [$clog2(MAX_VARS + 1)-1:0]  heap_count
);

	iph_pkg::iph_cmd_t cmd;
	iph_pkg::iph_sts_t sts;

	iph_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.busy(busy), .done(done), .cmd(cmd), .sts(sts));

	iph_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.var_index(var_index), .new_key(new_key),
		.popped_var(popped_var), .popped_valid(popped_valid),
		.empty_error(empty_error), .heap_count(heap_count));

endmodule
